### design/gda_pkg.sv
// Package for the Gregorian date arithmetic block.
// Holds the action codes, the field widths and the calendar helper functions.
// Used by gregorian_date_arithmetic_top; depends on nothing.
package gda_pkg;

	typedef enum logic [1:0] {
		ACT_ADD      = 2'd0,
		ACT_DIFF     = 2'd1,
		ACT_COMPARE  = 2'd2,
		ACT_RESERVED = 2'd3
	} action_t;

	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int DELTA_W  = 23;
	localparam int SERIAL_W = 25;
	localparam int YS_W     = 24;
	localparam int YWIDE_W  = 15;
	localparam int DOY_W    = 9;

	// just below 2^32 / 365.2425, never above the true ratio
	localparam logic [23:0] YEAR_RECIP = 24'd11759219;
	localparam int          YEAR_FIELD_MAX = 16383;

	typedef logic signed [SERIAL_W-1:0] serial_t;

	// days from 0000-01-01 to January 1 of year y
	function automatic logic [YS_W-1:0] year_start(input logic [YWIDE_W-1:0] y);
		logic [15:0] a4;
		logic [15:0] a100;
		logic [15:0] a400;
		logic [31:0] p100;
		logic [31:0] p400;
		logic [YS_W-1:0] base;
		a4   = 16'(y) + 16'd3;
		a100 = 16'(y) + 16'd99;
		a400 = 16'(y) + 16'd399;
		p100 = 32'(a100) * 32'd5243;
		p400 = 32'(a400) * 32'd5243;
		base = YS_W'(y) * YS_W'(365);
		return base + YS_W'(a4 >> 2) - YS_W'(p100 >> 19) + YS_W'(p400 >> 21);
	endfunction

	function automatic logic is_leap(input logic [YWIDE_W-1:0] y);
		logic [31:0] p;
		logic [YWIDE_W-1:0] q;
		logic [YWIDE_W-1:0] r;
		p = 32'(y) * 32'd5243;
		q = YWIDE_W'(p >> 19);
		r = y - YWIDE_W'(q * YWIDE_W'(100));
		return ((y[1:0] == 2'd0) && (r != '0)) || ((r == '0) && (q[1:0] == 2'd0));
	endfunction

	// days in the months before month m; month 0 adds none, above 12 all twelve
	function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DOY_W-1:0] c;
		unique case (m)
			4'd0, 4'd1: c = 9'd0;
			4'd2:  c = 9'd31;
			4'd3:  c = 9'd59;
			4'd4:  c = 9'd90;
			4'd5:  c = 9'd120;
			4'd6:  c = 9'd151;
			4'd7:  c = 9'd181;
			4'd8:  c = 9'd212;
			4'd9:  c = 9'd243;
			4'd10: c = 9'd273;
			4'd11: c = 9'd304;
			4'd12: c = 9'd334;
			default: c = 9'd365;
		endcase
		if (leap && m >= 4'd3) begin
			c = c + 9'd1;
		end
		return c;
	endfunction

endpackage

### design/gregorian_date_arithmetic_top.sv
// Gregorian date add, difference and compare, six-stage pipeline.
// Depends on gda_pkg for action codes, widths and calendar functions.
//
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | tdata: dates A, B, day_delta; tuser: action
// m_      | out | m_tvalid/m_tready  | tdata: moved date, difference, flags
//
// One item enters per cycle while the output is not stalled; each result leaves through every stage in turn.
// Stage split: year starts, serials, year estimate multiply, candidate years,
// year select, month walk into the output register.
// Reset clears the valid bits only. A stall at the output holds every stage.
module gregorian_date_arithmetic_top #(
	parameter int MAX_YEAR = 9999
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// first_day, first_month, first_year, second_day, second_month,
	// second_year, day_delta, zero fill
	input  logic [71:0] s_tdata,
	// action
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// result_day, result_month, result_year, day_difference, is_less,
	// is_equal, out_of_range, zero fill
	output logic [55:0] m_tdata
);

	localparam int SW = gda_pkg::SERIAL_W;
	localparam int YW = gda_pkg::YWIDE_W;
	localparam int YS = gda_pkg::YS_W;
	localparam int DW = gda_pkg::DOY_W;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// input unpack
	logic [4:0]  in_da, in_db;
	logic [3:0]  in_ma, in_mb;
	logic [13:0] in_ya, in_yb;

	assign in_da = s_tdata[4:0];
	assign in_ma = s_tdata[8:5];
	assign in_ya = s_tdata[22:9];
	assign in_db = s_tdata[27:23];
	assign in_mb = s_tdata[31:28];
	assign in_yb = s_tdata[45:32];

	assign adv      = !v_s6 || m_tready;
	assign s_tready = adv;
	assign m_tvalid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// stage 1: year starts, month offsets and compare flags
	logic [1:0]            act_s1, act_s2, act_s3, act_s4, act_s5;
	logic [4:0]            da_s1, db_s1;
	logic signed [22:0]    delta_s1;
	logic [YS-1:0]         ysa_s1, ysb_s1;
	logic [DW-1:0]         cuma_s1, cumb_s1;
	logic                  less_s1, eq_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1   <= s_tuser;
			da_s1    <= in_da;
			db_s1    <= in_db;
			delta_s1 <= s_tdata[68:46];
			ysa_s1   <= gda_pkg::year_start(YW'(in_ya));
			ysb_s1   <= gda_pkg::year_start(YW'(in_yb));
			cuma_s1  <= gda_pkg::cum_days(in_ma, gda_pkg::is_leap(YW'(in_ya)));
			cumb_s1  <= gda_pkg::cum_days(in_mb, gda_pkg::is_leap(YW'(in_yb)));
			less_s1  <= {in_ya, in_ma, in_da} < {in_yb, in_mb, in_db};
			eq_s1    <= {in_ya, in_ma, in_da} == {in_yb, in_mb, in_db};
		end
	end

	// stage 2: serials, moved serial, saturated difference
	gda_pkg::serial_t ser_a, ser_b, diff_w;
	gda_pkg::serial_t s_s2, s_s3, s_s4;
	logic signed [22:0] diff_s2, diff_s3, diff_s4, diff_s5;
	logic less_s2, less_s3, less_s4, less_s5;
	logic eq_s2, eq_s3, eq_s4, eq_s5;

	always_comb begin
		ser_a  = SW'(signed'({1'b0, ysa_s1})) + SW'(signed'({1'b0, cuma_s1}))
			+ SW'(signed'({1'b0, da_s1})) - SW'(1);
		ser_b  = SW'(signed'({1'b0, ysb_s1})) + SW'(signed'({1'b0, cumb_s1}))
			+ SW'(signed'({1'b0, db_s1})) - SW'(1);
		diff_w = ser_a - ser_b;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s2  <= act_s1;
			s_s2    <= ser_a + SW'(delta_s1);
			less_s2 <= less_s1;
			eq_s2   <= eq_s1;
			if (diff_w > SW'(4194303)) begin
				diff_s2 <= 23'sd4194303;
			end else if (diff_w < -SW'(4194304)) begin
				diff_s2 <= -23'sd4194304;
			end else begin
				diff_s2 <= diff_w[22:0];
			end
		end
	end

	// stage 3: year estimate, never above the true year and at most two below
	logic [23:0] est_t;
	logic [47:0] est_p;
	logic [YW-1:0] e_s3, e_s4;

	always_comb begin
		if (s_s2 < SW'(2)) begin
			est_t = '0;
		end else begin
			est_t = 24'(s_s2 - SW'(2));
		end
		est_p = 48'(est_t) * 48'(gda_pkg::YEAR_RECIP);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s3  <= act_s2;
			s_s3    <= s_s2;
			e_s3    <= est_p[32+YW-1:32];
			diff_s3 <= diff_s2;
			less_s3 <= less_s2;
			eq_s3   <= eq_s2;
		end
	end

	// stage 4: year starts of the three candidate years
	logic [YS-1:0] ys0_s4, ys1_s4, ys2_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s4  <= act_s3;
			s_s4    <= s_s3;
			e_s4    <= e_s3;
			ys0_s4  <= gda_pkg::year_start(e_s3);
			ys1_s4  <= gda_pkg::year_start(e_s3 + YW'(1));
			ys2_s4  <= gda_pkg::year_start(e_s3 + YW'(2));
			diff_s4 <= diff_s3;
			less_s4 <= less_s3;
			eq_s4   <= eq_s3;
		end
	end

	// stage 5: pick the year, day of year
	logic          c1, c2;
	logic [YS-1:0] s_u, ys_sel;
	logic [YW-1:0] y_s5;
	logic [DW-1:0] r_s5;
	logic          neg_s5;

	always_comb begin
		s_u = YS'(s_s4);
		c1  = ys1_s4 <= s_u;
		c2  = ys2_s4 <= s_u;
		priority if (c2) begin
			ys_sel = ys2_s4;
		end else if (c1) begin
			ys_sel = ys1_s4;
		end else begin
			ys_sel = ys0_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s5  <= act_s4;
			y_s5    <= e_s4 + YW'(c1) + YW'(c2);
			r_s5    <= DW'(s_u - ys_sel);
			neg_s5  <= s_s4 < 0;
			diff_s5 <= diff_s4;
			less_s5 <= less_s4;
			eq_s5   <= eq_s4;
		end
	end

	// stage 6: month walk and result assembly
	logic         lp;
	logic [3:0]   mon;
	logic [DW-1:0] doy_off;
	logic         oor;
	logic [55:0]  res_w;

	always_comb begin
		lp  = gda_pkg::is_leap(y_s5);
		mon = 4'd1;
		for (int k = 2; k <= 12; k++) begin
			if (gda_pkg::cum_days(4'(k), lp) <= r_s5) begin
				mon = mon + 4'd1;
			end
		end
		doy_off = r_s5 - gda_pkg::cum_days(mon, lp) + DW'(1);
		oor = neg_s5 || (32'(y_s5) > MAX_YEAR) || (32'(y_s5) > gda_pkg::YEAR_FIELD_MAX);
	end

	always_comb begin
		res_w = '0;
		if (act_s5 == gda_pkg::ACT_ADD) begin
			res_w[48] = oor;
			if (!oor) begin
				res_w[4:0]  = doy_off[4:0];
				res_w[8:5]  = mon;
				res_w[22:9] = y_s5[13:0];
			end
		end else if (act_s5 == gda_pkg::ACT_DIFF) begin
			res_w[45:23] = diff_s5;
		end else if (act_s5 == gda_pkg::ACT_COMPARE) begin
			res_w[46] = less_s5;
			res_w[47] = eq_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= res_w;
		end
	end

`ifndef ASSERT_OFF
	a_oor_clears_date: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[48] |-> m_tdata[22:0] == '0)
		else $error("out of range result carries a date");
	a_eq_not_less: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[47] |-> !m_tdata[46])
		else $error("equal and less both set");
	a_month_has_day: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8:5] != 4'd0 |-> m_tdata[4:0] != 5'd0 && m_tdata[8:5] <= 4'd12)
		else $error("moved date malformed");
	a_stall_only_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input held without output stall");
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted item lost at stage one");
`endif

endmodule
